// ----- hdl/fird3_pkg.sv -----
// Package for the FIR decimate-by-three block: widths, filter coefficients,
// sequencer states and configuration register indexes.
// No dependencies; used by the top level and its checker.
package fird3_pkg;

    // Field widths
    localparam int SAMPLE_W   = 24;                 // speech sample, Q16.8
    localparam int COEF_W     = 18;                 // coefficient, Q1.17
    localparam int GAIN_W     = 16;                 // gain, unsigned Q4.12
    localparam int PCM_W      = 16;                 // saturated PCM result

    // Filter geometry
    localparam int TAPS       = 45;
    localparam int TAP_IDX_W  = $clog2(TAPS);
    localparam int HALF_SPAN  = TAPS / 2;
    localparam int FLUSH_STEPS = HALF_SPAN - 2;     // zero samples pushed on flush
    localparam int K_W        = $clog2(FLUSH_STEPS + 1);
    localparam logic [1:0] CENTER_PHASE = 2'(HALF_SPAN % 3);

    // Datapath widths
    localparam int PROD_W     = SAMPLE_W + COEF_W;  // shared multiplier result
    localparam int ACC_W      = PROD_W;             // filter sum, |sum| < 2^41
    localparam int MAG_SPLIT  = 21;                 // magnitude split for gain
    localparam int LO_W       = MAG_SPLIT + GAIN_W; // one gain partial product
    localparam int TOTAL_W    = LO_W + MAG_SPLIT;   // full magnitude * gain

    // Output scaling shifts
    localparam int PASS_SHIFT = 8 + 12;             // Q.20 -> integer
    localparam int FILT_SHIFT = (COEF_W - 1) + 8 + 12; // Q.37 -> integer

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN   = 1'b1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET     = 16'd4096;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_TAIL,
        ST_GAIN_LO,
        ST_GAIN_HI,
        ST_GAIN_SUM,
        ST_SAT,
        ST_FLUSH
    } state_t;

    // Hamming-windowed sinc low-pass, cutoff 0.15 fs, taps sum to 2^17
    function automatic logic signed [COEF_W-1:0] lp_coef(input logic [TAP_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            6'd0,  6'd44: c = 18'sd144;
            6'd1,  6'd43: c = 18'sd136;
            6'd2,  6'd42: c = 18'sd0;
            6'd3,  6'd41: c = -18'sd216;
            6'd4,  6'd40: c = -18'sd337;
            6'd5,  6'd39: c = -18'sd146;
            6'd6,  6'd38: c = 18'sd365;
            6'd7,  6'd37: c = 18'sd809;
            6'd8,  6'd36: c = 18'sd610;
            6'd9,  6'd35: c = -18'sd406;
            6'd10, 6'd34: c = -18'sd1567;
            6'd11, 6'd33: c = -18'sd1654;
            6'd12, 6'd32: c = 18'sd0;
            6'd13, 6'd31: c = 18'sd2507;
            6'd14, 6'd30: c = 18'sd3620;
            6'd15, 6'd29: c = 18'sd1450;
            6'd16, 6'd28: c = -18'sd3433;
            6'd17, 6'd27: c = -18'sd7395;
            6'd18, 6'd26: c = -18'sd5674;
            6'd19, 6'd25: c = 18'sd4112;
            6'd20, 6'd24: c = 18'sd19438;
            6'd21, 6'd23: c = 18'sd33541;
            6'd22:        c = 18'sd39264;
            default:      c = 18'sd0;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/fir_decimate_by_three_gain_sat.sv -----
// Top level of the FIR decimate-by-three block with output gain and saturation.
// One shared 24x18 multiplier under a small sequencer; tap line in flip-flops.
// Depends on fird3_pkg.

// Each input item is a Q16.8 speech sample. With decim_mode 0 the sample is
// scaled by out_gain (Q4.12) through the two gain partial products, their sum
// and the saturate step, and saturated to 16 bits. With decim_mode 1 the sample
// enters a 45-tap low-pass delay line and, once HALF_SPAN samples have entered,
// every third sample yields one result; an item that yields a result runs the
// 45 passes of the single shared multiply-accumulate over the rotating tap
// line, one accumulate tail, the two gain partial products, their sum and the
// saturate step. No new sample is taken until the block is back in idle.
// In decim_mode 1 an item flagged with tlast flushes the pending outputs with
// 20 zero samples and then clears the line, with at most 7 flushed results;
// tlast marks the last result of the utterance (in decim_mode 0 it passes
// through with the result). A finished result waits in the output register
// while the block goes on; the next result holds in the saturate step until
// that register is free.
module fir_decimate_by_three_gain_sat (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fird3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fird3_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fird3_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [23:0] speech_sample
    input  logic                                s_axis_tlast,  // end_of_utterance
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fird3_pkg::PCM_W-1:0]         m_axis_tdata,  // [15:0] pcm_out
    output logic                                m_axis_tlast   // last_out
);
    import fird3_pkg::*;

    typedef enum logic [1:0] {
        TAP_HOLD,
        TAP_SHIFT,
        TAP_ROTATE,
        TAP_CLEAR
    } tap_op_t;

    // Control state
    state_t                  state_reg, state_next;
    logic                    decim_mode_reg, decim_mode_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;
    logic [31:0]             idx_reg, idx_next;
    logic [1:0]              ph_reg, ph_next;
    logic [1:0]              fph_reg, fph_next;
    logic [K_W-1:0]          k_reg, k_next;
    logic [TAP_IDX_W-1:0]    t_reg, t_next;
    logic                    flush_reg, flush_next;
    logic                    mode0_reg, mode0_next;
    logic                    last_reg, last_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload
    logic signed [SAMPLE_W-1:0] tap_reg [TAPS];
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [LO_W-1:0]            lo_reg, lo_next;
    logic [TOTAL_W-1:0]         total_reg, total_next;
    logic [PCM_W-1:0]           pcm_reg, pcm_next;
    logic                       out_last_reg, out_last_next;

    // Shared datapath signals
    tap_op_t                    tap_op;
    logic signed [SAMPLE_W-1:0] tap_din;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [COEF_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [ACC_W-1:0]           mag;
    logic [TOTAL_W-1:0]         q;
    logic [PCM_W-1:0]           sat_val;
    logic [31:0]                idx_inc;
    logic [1:0]                 ph_inc;
    logic [1:0]                 fph_inc;
    logic                       in_acc;
    logic                       normal_hit;
    logic                       flush_hit;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pcm_reg;
    assign m_axis_tlast  = out_last_reg;

    // Phase bookkeeping: ph tracks idx mod 3, fph tracks (idx + k) mod 3
    assign idx_inc    = idx_reg + 32'd1;
    assign ph_inc     = (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
    assign fph_inc    = (fph_reg == 2'd2) ? 2'd0 : fph_reg + 2'd1;
    assign normal_hit = (idx_reg >= 32'(HALF_SPAN)) && (ph_reg == CENTER_PHASE);
    assign flush_hit  = ((33'(idx_reg) + 33'(k_reg) + 33'd1) >= 33'(HALF_SPAN))
                        && (fph_inc == CENTER_PHASE);

    // Shared multiplier
    assign mul_p = mul_a * mul_b;

    // Magnitude of the value to be scaled
    assign mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    // Truncate and saturate
    always_comb
    begin
        q = total_reg >> (mode0_reg ? PASS_SHIFT : FILT_SHIFT);
        if (acc_reg[ACC_W-1])
        begin
            sat_val = (q > TOTAL_W'(32768)) ? 16'h8000 : PCM_W'(-q[PCM_W-1:0]);
        end
        else
        begin
            sat_val = (q > TOTAL_W'(32767)) ? 16'h7fff : q[PCM_W-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (!decim_mode_reg) state_next = ST_GAIN_LO;
                    else if (normal_hit)          state_next = ST_MAC;
                    else if (s_axis_tlast)        state_next = ST_FLUSH;
                    else                          state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                if (t_reg == TAP_IDX_W'(TAPS - 1))
                    state_next = ST_MAC_TAIL;
            end
            ST_MAC_TAIL: state_next = ST_GAIN_LO;
            ST_GAIN_LO:  state_next = ST_GAIN_HI;
            ST_GAIN_HI:  state_next = ST_GAIN_SUM;
            ST_GAIN_SUM: state_next = ST_SAT;
            ST_SAT:
            begin
                if (!out_valid_reg)
                    state_next = (!mode0_reg && flush_reg) ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH:
            begin
                priority if (k_reg == K_W'(FLUSH_STEPS)) state_next = ST_IDLE;
                else if (flush_hit)                      state_next = ST_MAC;
                else                                     state_next = ST_FLUSH;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and register updates
    always_comb
    begin
        decim_mode_next = decim_mode_reg;
        gain_next       = gain_reg;
        idx_next        = idx_reg;
        ph_next         = ph_reg;
        fph_next        = fph_reg;
        k_next          = k_reg;
        t_next          = t_reg;
        flush_next      = flush_reg;
        mode0_next      = mode0_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        lo_next         = lo_reg;
        total_next      = total_reg;
        pcm_next        = pcm_reg;
        out_last_next   = out_last_reg;
        tap_op          = TAP_HOLD;
        tap_din         = $signed(s_axis_tdata);
        mul_a           = tap_reg[TAPS-1];
        mul_b           = lp_coef(TAP_IDX_W'(TAPS - 1) - t_reg);

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DECIM_MODE: decim_mode_next = cfg_data[0];
                CFG_OUT_GAIN:   gain_next       = cfg_data;
                default:        ;
            endcase
        end

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!decim_mode_reg)
                    begin
                        mode0_next = 1'b1;
                        last_next  = s_axis_tlast;
                        acc_next   = ACC_W'($signed(s_axis_tdata));
                    end
                    else
                    begin
                        mode0_next = 1'b0;
                        last_next  = 1'b0;
                        flush_next = s_axis_tlast;
                        k_next     = '0;
                        t_next     = '0;
                        fph_next   = ph_reg;
                        tap_op     = TAP_SHIFT;
                        if (!s_axis_tlast)
                        begin
                            idx_next = idx_inc;
                            ph_next  = (idx_inc == 32'd0) ? 2'd0 : ph_inc;
                        end
                    end
                end
            end
            ST_MAC:
            begin
                tap_op    = TAP_ROTATE;
                prod_next = mul_p;
                acc_next  = (t_reg == '0) ? '0 : acc_reg + prod_reg;
                t_next    = t_reg + TAP_IDX_W'(1);
            end
            ST_MAC_TAIL:
            begin
                acc_next = acc_reg + prod_reg;
            end
            ST_GAIN_LO:
            begin
                mul_a     = $signed(SAMPLE_W'(mag[MAG_SPLIT-1:0]));
                mul_b     = $signed(COEF_W'(gain_reg));
                prod_next = mul_p;
            end
            ST_GAIN_HI:
            begin
                mul_a     = $signed(SAMPLE_W'(mag[ACC_W-1:MAG_SPLIT]));
                mul_b     = $signed(COEF_W'(gain_reg));
                prod_next = mul_p;
                lo_next   = prod_reg[LO_W-1:0];
            end
            ST_GAIN_SUM:
            begin
                total_next = TOTAL_W'(lo_reg) + {prod_reg[LO_W-1:0], {MAG_SPLIT{1'b0}}};
            end
            ST_SAT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    pcm_next       = sat_val;
                    out_last_next  = last_reg;
                end
            end
            ST_FLUSH:
            begin
                if (k_reg == K_W'(FLUSH_STEPS))
                begin
                    // utterance done: back to a clean line
                    tap_op   = TAP_CLEAR;
                    idx_next = '0;
                    ph_next  = '0;
                end
                else
                begin
                    tap_op    = TAP_SHIFT;
                    tap_din   = '0;
                    k_next    = k_reg + K_W'(1);
                    fph_next  = fph_inc;
                    t_next    = '0;
                    // no later flush step can hit once fewer than three steps remain before the end
                    last_next = (k_reg >= K_W'(FLUSH_STEPS - 3));
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            decim_mode_reg <= 1'b1;
            gain_reg       <= GAIN_RESET;
            idx_reg        <= '0;
            ph_reg         <= '0;
            fph_reg        <= '0;
            k_reg          <= '0;
            t_reg          <= '0;
            flush_reg      <= 1'b0;
            mode0_reg      <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            decim_mode_reg <= decim_mode_next;
            gain_reg       <= gain_next;
            idx_reg        <= idx_next;
            ph_reg         <= ph_next;
            fph_reg        <= fph_next;
            k_reg          <= k_next;
            t_reg          <= t_next;
            flush_reg      <= flush_next;
            mode0_reg      <= mode0_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Tap line: shift at the head, rotate through the tail for the MAC, clear after a flush
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TAPS; j++)
                tap_reg[j] <= '0;
        end
        else
        begin
            unique case (tap_op)
                TAP_SHIFT:
                begin
                    tap_reg[0] <= tap_din;
                    for (int j = 1; j < TAPS; j++)
                        tap_reg[j] <= tap_reg[j-1];
                end
                TAP_ROTATE:
                begin
                    tap_reg[0] <= tap_reg[TAPS-1];
                    for (int j = 1; j < TAPS; j++)
                        tap_reg[j] <= tap_reg[j-1];
                end
                TAP_CLEAR:
                begin
                    for (int j = 0; j < TAPS; j++)
                        tap_reg[j] <= '0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        lo_reg       <= lo_next;
        total_reg    <= total_next;
        pcm_reg      <= pcm_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- hdl/fird3_checker.sv -----
// Port-level checker for the FIR decimate-by-three block, bound to the top level.
// Watches the stream handshakes over time; depends on fird3_pkg.
module fird3_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [fird3_pkg::PCM_W-1:0]         m_axis_tdata,
    input logic                                m_axis_tlast
);

    // A stalled result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A new result only appears out of a busy cycle, never straight from idle
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while the block was idle");

    // Results are spaced by the saturate step, which loads only an empty output register: no two in adjacent cycles
    a_out_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("results delivered back to back");

    // The configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind fir_decimate_by_three_gain_sat fird3_checker u_fird3_checker (.*);
